[design/pfpa_pkg.sv]
// Shared types, codes and the colour distance function of the palette framebuffer.
package pfpa_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int PAL_AW       = 8;
	localparam int DIST_W       = 11;

	typedef logic [PAL_AW-1:0] pal_idx_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [6:0]        dim_t;
	typedef logic [2:0]        opcode_t;
	typedef logic [1:0]        res_sel_t;
	typedef logic [1:0]        cfg_index_t;

	localparam pal_idx_t PAL_LAST     = pal_idx_t'(PALETTE_SIZE - 1);
	localparam dist_t    NO_MATCH_YET = '1;

	localparam opcode_t OP_READ_COLOR   = 3'd0;
	localparam opcode_t OP_WRITE_COLOR  = 3'd1;
	localparam opcode_t OP_READ_RAW     = 3'd2;
	localparam opcode_t OP_WRITE_RAW    = 3'd3;
	localparam opcode_t OP_LOAD_PALETTE = 3'd4;

	localparam res_sel_t RES_ZERO    = 2'd0;
	localparam res_sel_t RES_PIXEL   = 2'd1;
	localparam res_sel_t RES_PALETTE = 2'd2;

	localparam cfg_index_t CFG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_index_t CFG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_index_t CFG_PALETTE_MODE = 2'd2;

	typedef struct packed {
		logic     load_item;
		logic     pix_rd;
		logic     pix_wr;
		logic     wr_best;
		logic     pal_wr;
		logic     pal_rd_pixel;
		logic     scan_init;
		logic     scan_step;
		logic     res_cap;
		res_sel_t res_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    in_bounds;
		logic    palette_mode;
		logic    scan_last;
	} dp_status_t;

	function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic dist_t color_distance(input logic [31:0] c, input logic [31:0] p);
		return dist_t'(absdiff8(c[31:24], p[31:24]))
		     + (dist_t'(absdiff8(c[23:16], p[23:16])) << 1)
		     + dist_t'(absdiff8(c[15:8], p[15:8]))
		     + (dist_t'(absdiff8(c[7:0], p[7:0])) << 1);
	endfunction

endpackage

[design/pfpa_datapath.sv]
// Datapath: configuration registers, pixel store, palette, nearest-colour scan and result registers.
module pfpa_datapath
	import pfpa_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  cfg_index_t  cfg_index,
	input  logic [6:0]  cfg_data,
	input  opcode_t     opcode,
	input  logic [11:0] pos_x,
	input  logic [11:0] pos_y,
	input  logic [31:0] value,
	input  pal_idx_t    palette_slot,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic [31:0] read_value
);

	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int W_CLIP_I   = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
	localparam int H_CLIP_I   = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
	localparam dim_t W_CLIP   = dim_t'(W_CLIP_I);
	localparam dim_t H_CLIP   = dim_t'(H_CLIP_I);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

	dim_t        width_q;
	dim_t        height_q;
	logic        mode_q;
	opcode_t     op_q;
	logic [11:0] x_q;
	logic [11:0] y_q;
	logic [31:0] value_q;
	pal_idx_t    slot_q;

	dim_t          eff_w;
	dim_t          eff_h;
	logic          in_bounds;
	logic [AW-1:0] pix_addr;
	logic [31:0]   pix_wdata;
	logic [31:0]   pix_mem [DEPTH];
	logic [31:0]   pix_rd_q;

	logic [31:0]             pal_mem [PALETTE_SIZE];
	logic [PALETTE_SIZE-1:0] pal_valid_q;
	logic [31:0]             pal_rd_q;
	logic                    pal_hit_q;
	pal_idx_t                pal_rd_addr;
	logic                    pal_rd_en;
	logic [31:0]             pal_data;

	pal_idx_t scan_cnt_q;
	logic     cmp_en_s1;
	pal_idx_t cmp_idx_s1;
	dist_t    best_d_q;
	pal_idx_t best_idx_q;
	dist_t    cand_dist;

	logic [31:0] res_q;
	logic [31:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				CFG_PALETTE_MODE: mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q    <= opcode;
			x_q     <= pos_x;
			y_q     <= pos_y;
			value_q <= value;
			slot_q  <= palette_slot;
		end
	end

	assign eff_w     = (width_q < W_CLIP) ? width_q : W_CLIP;
	assign eff_h     = (height_q < H_CLIP) ? height_q : H_CLIP;
	assign in_bounds = !x_q[11] && !y_q[11]
	                && ({1'b0, x_q[10:0]} < {5'd0, eff_w})
	                && ({1'b0, y_q[10:0]} < {5'd0, eff_h});
	assign pix_addr = AW'(y_q[6:0]) * ROW_STRIDE + AW'(x_q[6:0]);

	always_comb begin
		if (cmd.wr_best) begin
			pix_wdata = {24'd0, best_idx_q};
		end else if (mode_q) begin
			pix_wdata = {24'd0, value_q[7:0]};
		end else begin
			pix_wdata = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_wr) begin
			pix_mem[pix_addr] <= pix_wdata;
		end
		if (cmd.pix_rd) begin
			pix_rd_q <= pix_mem[pix_addr];
		end
	end

	assign pal_rd_addr = cmd.scan_step ? scan_cnt_q : pix_rd_q[7:0];
	assign pal_rd_en   = cmd.scan_step || cmd.pal_rd_pixel;

	always_ff @(posedge clk) begin
		if (cmd.pal_wr) begin
			pal_mem[slot_q] <= value_q;
		end
		if (pal_rd_en) begin
			pal_rd_q <= pal_mem[pal_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
			pal_hit_q   <= 1'b0;
		end else begin
			if (cmd.pal_wr) begin
				pal_valid_q[slot_q] <= 1'b1;
			end
			if (pal_rd_en) begin
				pal_hit_q <= pal_valid_q[pal_rd_addr];
			end
		end
	end

	// An entry never loaded reads as zero.
	assign pal_data  = pal_hit_q ? pal_rd_q : 32'd0;
	assign cand_dist = color_distance(value_q, pal_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			cmp_en_s1  <= 1'b0;
		end else begin
			cmp_en_s1 <= cmd.scan_step;
			if (cmd.scan_init) begin
				scan_cnt_q <= '0;
			end else if (cmd.scan_step) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end
	end

	// A strictly smaller distance is needed to replace the best, so the first minimum wins.
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			cmp_idx_s1 <= scan_cnt_q;
		end
		if (cmd.scan_init) begin
			best_d_q   <= NO_MATCH_YET;
			best_idx_q <= '0;
		end else if (cmp_en_s1 && (cand_dist < best_d_q)) begin
			best_d_q   <= cand_dist;
			best_idx_q <= cmp_idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_cap) begin
			case (cmd.res_sel)
				RES_PIXEL:   res_q <= mode_q ? {24'd0, pix_rd_q[7:0]} : pix_rd_q;
				RES_PALETTE: res_q <= pal_data;
				default:     res_q <= 32'd0;
			endcase
		end
		if (cmd.out_load) begin
			out_data_q <= res_q;
		end
	end

	assign read_value          = out_data_q;
	assign status.opcode       = op_q;
	assign status.in_bounds    = in_bounds;
	assign status.palette_mode = mode_q;
	assign status.scan_last    = (scan_cnt_q == PAL_LAST);

endmodule

[design/pfpa_ctrl.sv]
// Controller: sequences each operation and owns the input and output handshakes.
module pfpa_ctrl
	import pfpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_PIXRD    = 3'd2;
	localparam logic [2:0] S_PALRD    = 3'd3;
	localparam logic [2:0] S_SCAN     = 3'd4;
	localparam logic [2:0] S_SCAN_END = 3'd5;
	localparam logic [2:0] S_STORE    = 3'd6;
	localparam logic [2:0] S_RESULT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.opcode) inside
					OP_READ_COLOR, OP_READ_RAW: begin
						cmd.pix_rd = 1'b1;
						state_d    = S_PIXRD;
					end
					OP_WRITE_RAW: begin
						cmd.pix_wr = status.in_bounds;
						state_d    = S_IDLE;
					end
					OP_WRITE_COLOR: begin
						if (status.in_bounds && status.palette_mode) begin
							cmd.scan_init = 1'b1;
							state_d       = S_SCAN;
						end else begin
							cmd.pix_wr = status.in_bounds;
							state_d    = S_IDLE;
						end
					end
					OP_LOAD_PALETTE: begin
						cmd.pal_wr = 1'b1;
						state_d    = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_PIXRD: begin
				if (!status.in_bounds) begin
					cmd.res_cap = 1'b1;
					cmd.res_sel = RES_ZERO;
					state_d     = S_RESULT;
				end else if (status.opcode == OP_READ_COLOR && status.palette_mode) begin
					cmd.pal_rd_pixel = 1'b1;
					state_d          = S_PALRD;
				end else begin
					cmd.res_cap = 1'b1;
					cmd.res_sel = RES_PIXEL;
					state_d     = S_RESULT;
				end
			end
			S_PALRD: begin
				cmd.res_cap = 1'b1;
				cmd.res_sel = RES_PALETTE;
				state_d     = S_RESULT;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_STORE;
			S_STORE: begin
				cmd.pix_wr  = 1'b1;
				cmd.wr_best = 1'b1;
				state_d     = S_IDLE;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[design/palette_framebuffer_pixel_access.sv]
// Top level of the palette framebuffer: stream ports, configuration port and the two halves.
// A pixel store of MAX_WIDTH x MAX_HEIGHT words with a 256-entry RGBA palette, one operation
// per input beat, the operation code in s_axis_tuser. One item is in progress at a time. A
// read passes through a result register into the output register, and a colour read in
// paletted mode first looks the pixel's index up in the palette. A colour write in paletted
// mode finds the nearest entry by reading all 256 palette entries through the palette's
// single read port, one entry a cycle. The output register holds a result until it is
// taken, so the next item may start meanwhile; a read that finds it still full waits in its
// last step until it is free. Out-of-bounds reads return 0 and out-of-bounds writes are
// dropped. Configuration writes are taken every cycle and must only be issued while the
// block is idle.
module palette_framebuffer_pixel_access
	import pfpa_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // pos_x[11:0], pos_y[23:12], value[55:24], palette_slot[63:56]
	input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // read_value[31:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	pfpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	pfpa_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (s_axis_tuser),
		.pos_x        (s_axis_tdata[11:0]),
		.pos_y        (s_axis_tdata[23:12]),
		.value        (s_axis_tdata[55:24]),
		.palette_slot (s_axis_tdata[63:56]),
		.cmd          (cmd),
		.status       (status),
		.read_value   (m_axis_tdata)
	);

endmodule

[design/pfpa_checker.sv]
// Port-level checks of the palette framebuffer and the bind that attaches them.
module pfpa_checker
	import pfpa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [6:0]  cfg_data
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat withdrawn while stalled");

	// A stalled result beat keeps its data.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// Only one item is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in progress");

	// Writes and palette loads never raise a result.
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid
		&& (s_axis_tuser == OP_WRITE_COLOR || s_axis_tuser == OP_WRITE_RAW
		    || s_axis_tuser == OP_LOAD_PALETTE)
		|=> !m_axis_tvalid)
		else $error("result beat raised by a write");

endmodule

bind palette_framebuffer_pixel_access pfpa_checker u_pfpa_checker (.*);
